// ===== src/pita_pkg.sv =====
`timescale 1ns / 1ps
// pita_pkg: shared types, codes and default sizes for the process-id table allocator
// no dependencies; imported by every other file of the block but pita_chan_if

package pita_pkg;

    localparam int PID_W          = 6;
    localparam int CODE_W         = 32;
    localparam int DEF_TABLE_SIZE = 64;
    localparam int DEF_FIRST_ID   = 2;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_EXIT   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_GET    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BAD_PID = 2'd2
    } t_status;

    // which result the datapath stages
    typedef enum logic [2:0] {
        RES_KEEP  = 3'd0,
        RES_ECHO  = 3'd1,
        RES_BAD   = 3'd2,
        RES_FULL  = 3'd3,
        RES_ALLOC = 3'd4,
        RES_GET   = 3'd5
    } t_res_kind;

    typedef struct packed {
        logic [1:0]               op;
        logic [PID_W-1:0]         pid;
        logic                     has_parent;
        logic [PID_W-1:0]         parent_pid;
        logic signed [CODE_W-1:0] exit_value;
    } t_req;

    typedef struct packed {
        logic [1:0]               status;
        logic [PID_W-1:0]         result_pid;
        logic                     entry_valid;
        logic                     entry_exited;
        logic signed [CODE_W-1:0] entry_exit_value;
        logic                     entry_has_parent;
        logic [PID_W-1:0]         entry_parent_pid;
    } t_rsp;

    typedef struct packed {
        logic      load;
        logic      scan;
        logic      alloc_commit;
        logic      exit_start;
        logic      unlink;
        logic      remove;
        t_res_kind res;
        logic      emit;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic pid_ok;
        logic hit;
        logic last;
        logic out_free;
    } t_dp_status;

endpackage

// ===== src/pita_chan_if.sv =====
`timescale 1ns / 1ps
// pita_chan_if: valid/ready channel carrying one payload beat
// payload type is set per instance; no other dependencies

interface pita_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/pita_ctrl.sv =====
`timescale 1ns / 1ps
// pita_ctrl: sequencer for the table operations
// depends on pita_pkg; drives datapath commands, reads datapath status

module pita_ctrl import pita_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ALLOC,
        S_EXIT,
        S_READ,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.op == OP_ALLOC) begin
                    o_cmd.scan = 1'b1;
                    n_state    = S_ALLOC;
                end else if (!i_status.pid_ok) begin
                    o_cmd.res = RES_BAD;
                    n_state   = S_DONE;
                end else begin
                    unique case (i_status.op)
                        OP_EXIT: begin
                            o_cmd.exit_start = 1'b1;
                            o_cmd.scan       = 1'b1;
                            o_cmd.res        = RES_ECHO;
                            n_state          = S_EXIT;
                        end
                        OP_REMOVE: begin
                            o_cmd.remove = 1'b1;
                            o_cmd.res    = RES_ECHO;
                            n_state      = S_DONE;
                        end
                        OP_GET: begin
                            n_state = S_READ;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                o_cmd.scan = 1'b1;
                if (i_status.hit) begin
                    o_cmd.alloc_commit = 1'b1;
                    o_cmd.res          = RES_ALLOC;
                    n_state            = S_DONE;
                end else if (i_status.last) begin
                    o_cmd.res = RES_FULL;
                    n_state   = S_DONE;
                end
            end
            S_EXIT: begin
                o_cmd.scan   = 1'b1;
                o_cmd.unlink = 1'b1;
                if (i_status.last) begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                o_cmd.res = RES_GET;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/pita_dp.sv =====
`timescale 1ns / 1ps
// pita_dp: table flags, parent and exit-code memories, scan pipeline, result registers
// depends on pita_pkg; commanded by pita_ctrl

module pita_dp import pita_pkg::*; #(
    parameter int DEPTH    = DEF_TABLE_SIZE,
    parameter int FIRST_ID = DEF_FIRST_ID
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_req       i_req_data,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output t_rsp       o_rsp_data,
    output logic       o_rsp_valid,
    input  logic       i_rsp_ready
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [CNT_W-1:0] CNT_FIRST = CNT_W'(FIRST_ID);
    localparam logic [CNT_W-1:0] CNT_END   = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DEPTH - 1);
    localparam logic [PID_W-1:0] PID_FIRST = PID_W'(FIRST_ID);
    localparam logic [PID_W:0]   PID_END   = (PID_W + 1)'(DEPTH);

    t_req                     r_req;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_chk_valid;
    logic [IDX_W-1:0]         r_chk_idx;
    logic [DEPTH-1:0]         r_used;
    logic [DEPTH-1:0]         r_exited;
    logic [DEPTH-1:0]         r_linked;
    logic [PID_W-1:0]         r_parent_mem [DEPTH];
    logic [CODE_W-1:0]        r_code_mem   [DEPTH];
    logic [PID_W-1:0]         r_par_rd;
    logic [CODE_W-1:0]        r_code_rd;
    t_rsp                     r_res;
    t_rsp                     r_rsp;
    logic                     r_rsp_valid;

    logic [IDX_W-1:0]  pid_idx;
    logic              pid_in_range;
    logic              cnt_live;
    logic [IDX_W-1:0]  par_addr;
    logic [IDX_W-1:0]  p_idx;
    logic              p_alive;
    logic              hit;
    logic              unlink_hit;
    logic              code_we;
    logic [IDX_W-1:0]  code_waddr;
    logic [CODE_W-1:0] code_wdata;
    logic [PID_W-1:0]  new_parent;
    t_rsp              n_res;

    assign pid_idx      = r_req.pid[IDX_W-1:0];
    assign pid_in_range = (r_req.pid >= PID_FIRST) && ({1'b0, r_req.pid} < PID_END);
    assign cnt_live     = (r_cnt < CNT_END);
    assign par_addr     = (i_cmd.scan && cnt_live) ? r_cnt[IDX_W-1:0] : pid_idx;

    // reap test on the entry whose parent link just came out of memory
    assign p_idx   = r_par_rd[IDX_W-1:0];
    assign p_alive = (r_par_rd >= PID_FIRST) && ({1'b0, r_par_rd} < PID_END)
                     && r_used[p_idx] && !r_exited[p_idx];
    assign hit     = r_chk_valid && (!r_used[r_chk_idx]
                     || (r_exited[r_chk_idx] && (!r_linked[r_chk_idx] || !p_alive)));

    // child of the exiting process
    assign unlink_hit = r_chk_valid && (PID_W'(r_chk_idx) != r_req.pid)
                        && r_used[r_chk_idx] && r_linked[r_chk_idx]
                        && (r_par_rd == r_req.pid);

    assign new_parent = r_req.has_parent ? r_req.parent_pid : '0;

    always_comb begin
        code_we    = i_cmd.alloc_commit || i_cmd.exit_start;
        code_waddr = i_cmd.alloc_commit ? r_chk_idx : pid_idx;
        code_wdata = i_cmd.alloc_commit ? '0 : r_req.exit_value;
    end

    assign o_status.op       = t_op'(r_req.op);
    assign o_status.pid_ok   = pid_in_range && r_used[pid_idx];
    assign o_status.hit      = hit;
    assign o_status.last     = r_chk_valid && (r_chk_idx == IDX_LAST);
    assign o_status.out_free = !r_rsp_valid || i_rsp_ready;

    // request capture and scan address
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req_data;
        end
        if (i_cmd.load) begin
            r_cnt <= CNT_FIRST;
        end else if (i_cmd.scan && cnt_live) begin
            r_cnt <= r_cnt + 1'b1;
        end
        r_chk_idx <= r_cnt[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_chk_valid <= 1'b0;
        end else begin
            r_chk_valid <= i_cmd.scan && cnt_live;
        end
    end

    // parent and exit-code memories, registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc_commit) begin
            r_parent_mem[r_chk_idx] <= new_parent;
        end
        if (code_we) begin
            r_code_mem[code_waddr] <= code_wdata;
        end
        r_par_rd  <= r_parent_mem[par_addr];
        r_code_rd <= r_code_mem[pid_idx];
    end

    // per-entry flags, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_exited <= '0;
            r_linked <= '0;
        end else begin
            if (i_cmd.alloc_commit) begin
                r_used[r_chk_idx]   <= 1'b1;
                r_exited[r_chk_idx] <= 1'b0;
                r_linked[r_chk_idx] <= r_req.has_parent;
            end
            if (i_cmd.exit_start) begin
                r_exited[pid_idx] <= 1'b1;
            end
            if (i_cmd.remove) begin
                r_used[pid_idx]   <= 1'b0;
                r_exited[pid_idx] <= 1'b0;
                r_linked[pid_idx] <= 1'b0;
            end
            if (i_cmd.unlink && unlink_hit) begin
                r_linked[r_chk_idx] <= 1'b0;
            end
        end
    end

    always_comb begin
        n_res = r_res;
        case (i_cmd.res)
            RES_ECHO: begin
                n_res            = '0;
                n_res.status     = ST_OK;
                n_res.result_pid = r_req.pid;
            end
            RES_BAD: begin
                n_res            = '0;
                n_res.status     = ST_BAD_PID;
                n_res.result_pid = r_req.pid;
            end
            RES_FULL: begin
                n_res        = '0;
                n_res.status = ST_FULL;
            end
            RES_ALLOC: begin
                n_res            = '0;
                n_res.status     = ST_OK;
                n_res.result_pid = PID_W'(r_chk_idx);
            end
            RES_GET: begin
                n_res                  = '0;
                n_res.status           = ST_OK;
                n_res.result_pid       = r_req.pid;
                n_res.entry_valid      = 1'b1;
                n_res.entry_exited     = r_exited[pid_idx];
                n_res.entry_exit_value = r_code_rd;
                n_res.entry_has_parent = r_linked[pid_idx];
                n_res.entry_parent_pid = r_linked[pid_idx] ? r_par_rd : '0;
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (i_cmd.emit) begin
            r_rsp <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    assign o_rsp_data  = r_rsp;
    assign o_rsp_valid = r_rsp_valid;

endmodule

// ===== src/process_id_table_allocator_unit.sv =====
`timescale 1ns / 1ps
// one request at a time: the next request beat is taken the cycle after the response is
//   loaded into the output register, which waits until that register is free; allocate
//   scans the table one entry a cycle up to the first free or reapable slot or the end,
//   exit scans every usable entry to unlink the children of the exiting process
// reset clears the used, exited and parent-link flags; parent and exit-code
//   memories are not cleared and need no clearing pass

module process_id_table_allocator_unit import pita_pkg::*; #(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE,
    parameter int FIRST_ID   = DEF_FIRST_ID
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pita_chan_if.sink   i_req,
    pita_chan_if.source o_rsp
);

    // ids are 6 bits wide, so only the first 64 slots can ever be reached
    localparam int DEPTH = (TABLE_SIZE < 64) ? TABLE_SIZE : 64;

    t_dp_cmd    cmd;
    t_dp_status dp_status;

    // sequencer: accept, decode, scan or read where the op needs it, then hand the result to the output register
    pita_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_status    (dp_status),
        .o_cmd       (cmd)
    );

    // flags, memories, scan pipeline and the response register
    pita_dp #(
        .DEPTH    (DEPTH),
        .FIRST_ID (FIRST_ID)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_data  (i_req.data),
        .i_cmd       (cmd),
        .o_status    (dp_status),
        .o_rsp_data  (o_rsp.data),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready)
    );

endmodule

// ===== src/pita_checker.sv =====
`timescale 1ns / 1ps
// pita_checker: port-level checks on the allocator's request and response beats
// depends on pita_pkg; bound to process_id_table_allocator_unit below

module pita_checker import pita_pkg::*; #(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE,
    parameter int FIRST_ID   = DEF_FIRST_ID
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp i_rsp
);

    localparam int DEPTH = (TABLE_SIZE < 64) ? TABLE_SIZE : 64;
    localparam logic [PID_W-1:0] PID_FIRST = PID_W'(FIRST_ID);
    localparam logic [PID_W:0]   PID_END   = (PID_W + 1)'(DEPTH);

    // stalled response beat holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp))
        else $error("response beat changed while stalled");

    // one request in flight
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while one is in progress");

    // full table reports no id and no entry
    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp.status == ST_FULL) |->
            (i_rsp.result_pid == '0) && !i_rsp.entry_valid)
        else $error("table-full beat carries data");

    // entry fields are zero unless a get succeeded, parent zero when unlinked
    a_entry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (!i_rsp.entry_valid || !i_rsp.entry_has_parent) |->
            (i_rsp.entry_parent_pid == '0) && (i_rsp.entry_valid
            || (!i_rsp.entry_exited && !i_rsp.entry_has_parent
                && (i_rsp.entry_exit_value == '0))))
        else $error("entry fields set outside a successful get");

    // a reported entry sits in the usable id range with ok status
    a_get_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp.entry_valid |->
            (i_rsp.status == ST_OK) && (i_rsp.result_pid >= PID_FIRST)
            && ({1'b0, i_rsp.result_pid} < PID_END))
        else $error("get reported an entry outside the usable ids");

endmodule

bind process_id_table_allocator_unit pita_checker #(
    .TABLE_SIZE (TABLE_SIZE),
    .FIRST_ID   (FIRST_ID)
) u_pita_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.data)
);

// ===== tb/process_id_table_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
// process_id_table_allocator_unit_tb: self-checking bench for the process-id table allocator
// depends on pita_pkg, pita_chan_if and process_id_table_allocator_unit; reads no files

module process_id_table_allocator_unit_tb;
    import pita_pkg::*;

    localparam int TB_TABLE_SIZE = DEF_TABLE_SIZE;
    localparam int TB_FIRST_ID   = DEF_FIRST_ID;
    localparam int ID_LIMIT      = (TB_TABLE_SIZE < 64) ? TB_TABLE_SIZE : 64;
    localparam int RANDOM_BEATS  = 450;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 80;
    localparam int STALL_LIMIT   = 3000;

    // mirror of the pid table plus the queue of responses still owed by the block
    class pid_table_mirror;
        bit       used    [64];
        bit       exited  [64];
        bit       linked  [64];
        bit [5:0] up_pid  [64];
        bit [31:0] code   [64];
        t_rsp     rsp_due [$];
        int       errors;
        int       n_op    [4];
        int       n_full;
        int       n_bad;
        int       n_reclaim;

        function new();
            errors    = 0;
            n_full    = 0;
            n_bad     = 0;
            n_reclaim = 0;
            foreach (n_op[i]) n_op[i] = 0;
        endfunction

        function bit usable(int id);
            return id >= TB_FIRST_ID && id < ID_LIMIT;
        endfunction

        function bit parent_gone(int id);
            int p;
            if (!linked[id]) return 1'b1;
            p = up_pid[id];
            if (!usable(p)) return 1'b1;
            return exited[p] || !used[p];
        endfunction

        function bit slot_claimable(int id);
            return !used[id] || (exited[id] && parent_gone(id));
        endfunction

        function bit can_allocate();
            for (int id = TB_FIRST_ID; id < ID_LIMIT; id++)
                if (slot_claimable(id)) return 1'b1;
            return 1'b0;
        endfunction

        function void clear_slot(int id);
            used[id]   = 1'b0;
            exited[id] = 1'b0;
            linked[id] = 1'b0;
            up_pid[id] = '0;
            code[id]   = '0;
        endfunction

        // a live id most of the time, any id now and then
        function logic [5:0] pick_pid(bit running_only);
            int ids[$];
            for (int id = TB_FIRST_ID; id < ID_LIMIT; id++)
                if (used[id] && !(running_only && exited[id])) ids.push_back(id);
            if (ids.size() == 0 || $urandom_range(0, 99) < 15)
                return 6'($urandom_range(0, 63));
            return 6'(ids[$urandom_range(0, ids.size() - 1)]);
        endfunction

        function t_rsp predict_rsp(t_req rq);
            t_rsp r;
            int   slot;
            int   pid;
            bit   found;
            r            = '0;
            r.result_pid = rq.pid;
            pid          = rq.pid;
            found        = 1'b0;
            slot         = 0;
            n_op[rq.op]++;
            if (rq.op == OP_ALLOC) begin
                for (int id = TB_FIRST_ID; id < ID_LIMIT; id++) begin
                    if (!found && slot_claimable(id)) begin
                        slot  = id;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    r.status     = ST_FULL;
                    r.result_pid = '0;
                    n_full++;
                end else begin
                    if (used[slot]) n_reclaim++;
                    clear_slot(slot);
                    used[slot]   = 1'b1;
                    linked[slot] = rq.has_parent;
                    up_pid[slot] = rq.has_parent ? rq.parent_pid : 6'd0;
                    r.status     = ST_OK;
                    r.result_pid = 6'(slot);
                end
                return r;
            end
            if (!usable(pid) || !used[pid]) begin
                r.status = ST_BAD_PID;
                n_bad++;
                return r;
            end
            case (rq.op)
                OP_EXIT: begin
                    code[pid]   = rq.exit_value;
                    exited[pid] = 1'b1;
                    // orphan the children, whether or not this process has a parent itself
                    for (int i = TB_FIRST_ID; i < ID_LIMIT; i++)
                        if (i != pid && used[i] && linked[i] && up_pid[i] == pid)
                            linked[i] = 1'b0;
                end
                OP_REMOVE: clear_slot(pid);
                default: begin
                    r.entry_valid      = 1'b1;
                    r.entry_exited     = exited[pid];
                    r.entry_exit_value = code[pid];
                    r.entry_has_parent = linked[pid];
                    r.entry_parent_pid = linked[pid] ? up_pid[pid] : 6'd0;
                end
            endcase
            r.status = ST_OK;
            return r;
        endfunction

        function void note_request(t_req rq);
            rsp_due.push_back(predict_rsp(rq));
        endfunction

        function int field_diff(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
                return 1;
            end
            return 0;
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            int   bad;
            if (rsp_due.size() == 0) begin
                $display("%0t ns: response beat with nothing pending, status %0d pid %0d",
                         $time, got.status, got.result_pid);
                errors++;
                return;
            end
            want = rsp_due.pop_front();
            bad  = field_diff("status", want.status, got.status)
                 + field_diff("result_pid", want.result_pid, got.result_pid)
                 + field_diff("entry_valid", want.entry_valid, got.entry_valid)
                 + field_diff("entry_exited", want.entry_exited, got.entry_exited)
                 + field_diff("entry_exit_value", want.entry_exit_value, got.entry_exit_value)
                 + field_diff("entry_has_parent", want.entry_has_parent, got.entry_has_parent)
                 + field_diff("entry_parent_pid", want.entry_parent_pid, got.entry_parent_pid);
            if (bad != 0) errors++;
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    pita_chan_if #(.T(t_req)) req_if ();
    pita_chan_if #(.T(t_rsp)) rsp_if ();

    process_id_table_allocator_unit #(
        .TABLE_SIZE (TB_TABLE_SIZE),
        .FIRST_ID   (TB_FIRST_ID)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    pid_table_mirror mirror = new();

    bit calm      = 1'b0;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;
    int rand_beats = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // offer one request beat, with an optional idle burst first
    task automatic send_req(input t_req rq);
        int gap;
        gap = 0;
        if (!calm && !(hold_req && !hold_done) && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 16);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= rq;
        do @(posedge i_clk); while (!req_if.ready);
        mirror.note_request(rq);
    endtask

    task automatic issue(input t_op op, input logic [5:0] pid, input bit has_par,
                         input logic [5:0] par, input logic [31:0] code);
        t_req rq;
        rq.op         = op;
        rq.pid        = pid;
        rq.has_parent = has_par;
        rq.parent_pid = par;
        rq.exit_value = code;
        send_req(rq);
    endtask

    // random beat; fields that the op ignores carry noise
    task automatic random_beat(input int mode, input bit alloc_only);
        t_req rq;
        int   roll;
        int   w_alloc;
        int   w_exit;
        int   w_remove;
        rq.pid        = 6'($urandom);
        rq.has_parent = 1'($urandom);
        rq.parent_pid = 6'($urandom);
        rq.exit_value = $urandom;
        case (mode)
            0:       begin w_alloc = 55; w_exit = 15; w_remove = 5;  end
            1:       begin w_alloc = 30; w_exit = 25; w_remove = 15; end
            default: begin w_alloc = 10; w_exit = 40; w_remove = 25; end
        endcase
        roll = alloc_only ? 0 : $urandom_range(0, 99);
        if (roll < w_alloc) begin
            rq.op = OP_ALLOC;
            if ($urandom_range(0, 9) < 7) rq.parent_pid = mirror.pick_pid(1'b1);
        end else if (roll < w_alloc + w_exit) begin
            rq.op  = OP_EXIT;
            rq.pid = mirror.pick_pid(1'b0);
        end else if (roll < w_alloc + w_exit + w_remove) begin
            rq.op  = OP_REMOVE;
            rq.pid = mirror.pick_pid(1'b0);
        end else begin
            rq.op  = OP_GET;
            rq.pid = mirror.pick_pid(1'b0);
        end
        send_req(rq);
        rand_beats++;
        if (rand_beats >= 150) hold_req = 1'b1;
        if (rand_beats >= RANDOM_BEATS - 60) calm = 1'b1;
    endtask

    // allocate until the table is full, then knock on it a few more times
    task automatic fill_table();
        while (mirror.can_allocate()) random_beat(0, 1'b1);
        repeat (3) random_beat(0, 1'b1);
    endtask

    // response side: random stalls, one long hold-off, none near the end
    initial begin
        rsp_if.ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                rsp_if.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) mirror.check_response(rsp_if.data);
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t ns: no beat on either channel for %0d cycles", $time, STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin
        int fills;
        fills = 0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bad and empty ids on an empty table
        issue(OP_GET,    6'd0,  1'b0, 6'd0,  32'h0);
        issue(OP_EXIT,   6'd1,  1'b0, 6'd0,  32'h0);
        issue(OP_REMOVE, 6'd63, 1'b0, 6'd0,  32'h0);
        issue(OP_GET,    6'd63, 1'b0, 6'd0,  32'h0);
        // first allocations, parent links unchecked
        issue(OP_ALLOC,  6'd0,  1'b0, 6'd0,  32'h0);
        issue(OP_ALLOC,  6'd0,  1'b1, 6'd2,  32'h0);
        issue(OP_ALLOC,  6'd0,  1'b1, 6'd63, 32'h0);
        issue(OP_ALLOC,  6'd0,  1'b1, 6'd0,  32'h0);
        issue(OP_GET,    6'd3,  1'b0, 6'd0,  32'h0);
        issue(OP_GET,    6'd4,  1'b0, 6'd0,  32'h0);
        // parentless exit still orphans its child
        issue(OP_EXIT,   6'd2,  1'b0, 6'd0,  32'h7fff_ffff);
        issue(OP_GET,    6'd3,  1'b0, 6'd0,  32'h0);
        issue(OP_GET,    6'd2,  1'b0, 6'd0,  32'h0);
        // repeated exit overwrites the code
        issue(OP_EXIT,   6'd2,  1'b0, 6'd0,  32'h8000_0000);
        issue(OP_GET,    6'd2,  1'b0, 6'd0,  32'h0);
        // reap the exited parentless slot, it comes back running with code 0
        issue(OP_ALLOC,  6'd0,  1'b1, 6'd3,  32'h0);
        issue(OP_GET,    6'd2,  1'b0, 6'd0,  32'h0);
        issue(OP_EXIT,   6'd3,  1'b0, 6'd0,  32'hffff_ffff);
        // parent link to an unused id counts as gone
        issue(OP_EXIT,   6'd4,  1'b0, 6'd0,  32'h0);
        issue(OP_REMOVE, 6'd5,  1'b0, 6'd0,  32'h0);
        issue(OP_GET,    6'd5,  1'b0, 6'd0,  32'h0);
        issue(OP_ALLOC,  6'd0,  1'b0, 6'd0,  32'h0);
        issue(OP_ALLOC,  6'd0,  1'b0, 6'd0,  32'h0);
        issue(OP_ALLOC,  6'd63, 1'b0, 6'd63, 32'hffff_ffff);

        while (rand_beats < RANDOM_BEATS) begin
            if ((fills == 0 && rand_beats >= 80) || (fills == 1 && rand_beats >= 300)) begin
                fill_table();
                fills++;
            end else begin
                random_beat((rand_beats / 40) % 3, 1'b0);
            end
        end
        req_if.valid <= 1'b0;

        while (mirror.rsp_due.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d beats: %0d allocate, %0d exit, %0d remove, %0d get",
                 mirror.n_op[0] + mirror.n_op[1] + mirror.n_op[2] + mirror.n_op[3],
                 mirror.n_op[0], mirror.n_op[1], mirror.n_op[2], mirror.n_op[3]);
        $display("%0d table-full, %0d bad-id answers, %0d slots reaped, %0d bad responses",
                 mirror.n_full, mirror.n_bad, mirror.n_reclaim, mirror.errors);
        if (mirror.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== process_id_table_allocator_unit.f =====
src/pita_pkg.sv
src/pita_chan_if.sv
src/pita_ctrl.sv
src/pita_dp.sv
src/process_id_table_allocator_unit.sv
src/pita_checker.sv
tb/process_id_table_allocator_unit_tb.sv
